[design/phd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_pkg
// Shared constants, codes and controller/datapath interface types for the
// pH dosing PID controller.
// ----------------------------------------------------------------------------
package phd_pkg;

  localparam int PH_W     = 14;
  localparam int DB_W     = 12;
  localparam int GAIN_W   = 20;
  localparam int TIME_W   = 32;
  localparam int ERR_W    = 15;
  localparam int DERR_W   = 16;
  localparam int INTEG_W  = 27;
  localparam int PULSE_W  = 13;
  localparam int ACT_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 27;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int SUM_W    = 48;
  localparam int ACC_W    = PROD_W + 1;

  localparam int DIV_NUM_W   = 46;
  localparam int DIV_DEN_W   = 32;
  localparam int DIV_STEPS   = DIV_NUM_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [TIME_W-1:0]  WINDOW_MS    = 32'd10000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_MS = 13'd5000;
  localparam logic [INTEG_W-1:0] INTEG_LIM    = 27'd51200000;
  localparam logic [DIV_DEN_W-1:0] MS_PER_S   = 32'd1000;

  localparam logic [PH_W-1:0]   TARGET_RESET   = 14'd7168;
  localparam logic [DB_W-1:0]   DEADBAND_RESET = 12'd102;
  localparam logic [GAIN_W-1:0] GAIN_P_RESET   = 20'd25600;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET   = 20'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET   = 20'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd4;

  localparam logic [ACT_W-1:0] ACT_KEEP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOW  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HIGH = 2'd2;

  localparam logic [1:0] MUL_EDT = 2'd0;
  localparam logic [1:0] MUL_P   = 2'd1;
  localparam logic [1:0] MUL_I   = 2'd2;
  localparam logic [1:0] MUL_D   = 2'd3;

  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_BAND = 2'd1;
  localparam logic [1:0] FIN_ZERO = 2'd2;
  localparam logic [1:0] FIN_PID  = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       ld_prod;
    logic [1:0] mul_op;
    logic       ld_integ;
    logic       ld_sum_p;
    logic       div_start;
    logic       div_sel_d;
    logic       add_q;
    logic [1:0] fin;
  } cmd_t;

  typedef struct packed {
    logic band;
    logic dt_zero;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

[design/phd_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module phd_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [phd_pkg::DIV_NUM_W-1:0] num,
  input  logic [phd_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [phd_pkg::DIV_NUM_W-1:0] quot
);

  logic [phd_pkg::DIV_NUM_W-1:0] nq;
  logic [phd_pkg::DIV_NUM_W-1:0] nq_next;
  logic [phd_pkg::DIV_DEN_W-1:0] rem;
  logic [phd_pkg::DIV_DEN_W-1:0] rem_next;
  logic [phd_pkg::DIV_DEN_W-1:0] dd;
  logic [phd_pkg::DIV_CNT_W-1:0] cnt;

  always_comb begin
    logic [phd_pkg::DIV_DEN_W:0]   t;
    logic [phd_pkg::DIV_NUM_W-1:0] q;
    logic [phd_pkg::DIV_DEN_W-1:0] r;
    q = nq;
    r = rem;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[phd_pkg::DIV_NUM_W-1]};
      q = {q[phd_pkg::DIV_NUM_W-2:0], 1'b0};
      if (t >= {1'b0, dd}) begin
        t = t - {1'b0, dd};
        q[0] = 1'b1;
      end
      r = t[phd_pkg::DIV_DEN_W-1:0];
    end
    nq_next  = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      nq   <= num;
      rem  <= '0;
      dd   <= den;
    end else if (busy) begin
      nq  <= nq_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == phd_pkg::DIV_CNT_W'(phd_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = nq;

endmodule

[design/phd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_datapath
// Configuration registers, controller state, shared multiplier, divider
// and output word register.
// ----------------------------------------------------------------------------
module phd_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  phd_pkg::cmd_t                   cmd,
  output phd_pkg::status_t                status,
  input  logic                            cfg_valid,
  input  logic [phd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [phd_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [phd_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic [phd_pkg::PH_W-1:0]   target_ph;
  logic [phd_pkg::DB_W-1:0]   deadband;
  logic [phd_pkg::GAIN_W-1:0] gain_p;
  logic [phd_pkg::GAIN_W-1:0] gain_i;
  logic [phd_pkg::GAIN_W-1:0] gain_d;

  logic signed [phd_pkg::INTEG_W-1:0] integral_acc;
  logic signed [phd_pkg::ERR_W-1:0]   previous_error;
  logic [phd_pkg::TIME_W-1:0]         last_update_time;
  logic [phd_pkg::TIME_W-1:0]         window_start_time;

  logic signed [phd_pkg::ERR_W-1:0] err;
  logic [phd_pkg::TIME_W-1:0]       dt;
  logic [phd_pkg::TIME_W-1:0]       now;
  logic                             acid_busy;
  logic                             base_busy;

  logic signed [phd_pkg::PROD_W-1:0] prod;
  logic signed [phd_pkg::SUM_W-1:0]  sum;
  logic signed [phd_pkg::SUM_W-1:0]  dnum;
  logic                              q_neg;

  logic [phd_pkg::ACT_W-1:0]   acid_action;
  logic [phd_pkg::ACT_W-1:0]   base_action;
  logic [phd_pkg::PULSE_W-1:0] pulse_ms;
  logic                        in_deadband;

  // capture
  logic signed [phd_pkg::ERR_W-1:0] err_in;
  logic [phd_pkg::TIME_W-1:0]       now_in;
  assign err_in = $signed({1'b0, s_tdata[phd_pkg::PH_W-1:0]}) - $signed({1'b0, target_ph});
  assign now_in = s_tdata[phd_pkg::PH_W +: phd_pkg::TIME_W];

  logic [phd_pkg::ERR_W-1:0] err_mag;
  assign err_mag = err[phd_pkg::ERR_W-1] ? phd_pkg::ERR_W'(-err) : err;

  assign status.band     = err_mag < {3'b000, deadband};
  assign status.dt_zero  = (dt == '0);
  assign status.out_free = !m_tvalid || m_tready;

  // shared multiplier
  logic signed [phd_pkg::DERR_W-1:0]  derr;
  logic signed [phd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [phd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [phd_pkg::PROD_W-1:0]  mul_y;

  assign derr = phd_pkg::DERR_W'(err) - phd_pkg::DERR_W'(previous_error);

  always_comb begin
    case (cmd.mul_op)
      phd_pkg::MUL_EDT: begin
        mul_a = $signed({1'b0, dt});
        mul_b = phd_pkg::MUL_B_W'(err);
      end
      phd_pkg::MUL_P: begin
        mul_a = $signed({13'd0, gain_p});
        mul_b = phd_pkg::MUL_B_W'(err);
      end
      phd_pkg::MUL_I: begin
        mul_a = $signed({13'd0, gain_i});
        mul_b = integral_acc;
      end
      phd_pkg::MUL_D: begin
        mul_a = $signed({13'd0, gain_d});
        mul_b = phd_pkg::MUL_B_W'(derr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_y = mul_a * mul_b;

  // integral update with clamp
  logic signed [phd_pkg::ACC_W-1:0]   acc_raw;
  logic signed [phd_pkg::INTEG_W-1:0] acc_clamped;
  assign acc_raw = phd_pkg::ACC_W'(integral_acc) + phd_pkg::ACC_W'(prod);

  always_comb begin
    if (acc_raw > $signed(phd_pkg::ACC_W'(phd_pkg::INTEG_LIM))) begin
      acc_clamped = $signed(phd_pkg::INTEG_LIM);
    end else if (acc_raw < -$signed(phd_pkg::ACC_W'(phd_pkg::INTEG_LIM))) begin
      acc_clamped = -$signed(phd_pkg::INTEG_LIM);
    end else begin
      acc_clamped = acc_raw[phd_pkg::INTEG_W-1:0];
    end
  end

  // divider
  logic signed [phd_pkg::SUM_W-1:0]  prod_s;
  logic signed [phd_pkg::SUM_W-1:0]  div_src;
  logic [phd_pkg::SUM_W-1:0]         div_mag;
  logic [phd_pkg::DIV_DEN_W-1:0]     div_den;
  logic [phd_pkg::DIV_NUM_W-1:0]     quot;
  logic signed [phd_pkg::SUM_W-1:0]  quot_s;
  logic                              div_busy;

  assign prod_s  = prod[phd_pkg::SUM_W-1:0];
  assign div_src = cmd.div_sel_d ? dnum : prod_s;
  assign div_mag = div_src[phd_pkg::SUM_W-1] ? phd_pkg::SUM_W'(-div_src) : div_src;
  assign div_den = cmd.div_sel_d ? dt : phd_pkg::MS_PER_S;
  assign quot_s  = q_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign status.div_busy = div_busy;

  phd_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_mag[phd_pkg::DIV_NUM_W-1:0]),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  // pulse and window
  logic [phd_pkg::SUM_W-1:0]   sum_mag;
  logic [phd_pkg::SUM_W-19:0]  pulse_full;
  logic [phd_pkg::PULSE_W-1:0] pulse;
  logic [phd_pkg::TIME_W-1:0]  wt_raw;
  logic                        wrap;
  logic [phd_pkg::TIME_W-1:0]  wt;
  logic [phd_pkg::ACT_W-1:0]   drive;

  assign sum_mag    = sum[phd_pkg::SUM_W-1] ? phd_pkg::SUM_W'(-sum) : sum;
  assign pulse_full = sum_mag[phd_pkg::SUM_W-1:18];
  assign pulse      = (pulse_full > {17'd0, phd_pkg::MAX_PULSE_MS}) ? phd_pkg::MAX_PULSE_MS
                                                                  : pulse_full[12:0];
  assign wt_raw = now - window_start_time;
  assign wrap   = wt_raw >= phd_pkg::WINDOW_MS;
  assign wt     = wrap ? '0 : wt_raw;
  assign drive  = (wt < {19'd0, pulse}) ? phd_pkg::ACT_HIGH : phd_pkg::ACT_LOW;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ph         <= phd_pkg::TARGET_RESET;
      deadband          <= phd_pkg::DEADBAND_RESET;
      gain_p            <= phd_pkg::GAIN_P_RESET;
      gain_i            <= phd_pkg::GAIN_I_RESET;
      gain_d            <= phd_pkg::GAIN_D_RESET;
      integral_acc      <= '0;
      previous_error    <= '0;
      last_update_time  <= '0;
      window_start_time <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          phd_pkg::CFG_TARGET:   target_ph <= cfg_data[phd_pkg::PH_W-1:0];
          phd_pkg::CFG_DEADBAND: deadband  <= cfg_data[phd_pkg::DB_W-1:0];
          phd_pkg::CFG_GAIN_P:   gain_p    <= cfg_data;
          phd_pkg::CFG_GAIN_I:   gain_i    <= cfg_data;
          phd_pkg::CFG_GAIN_D:   gain_d    <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.ld_integ) begin
        integral_acc <= acc_clamped;
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (cmd.fin)
        phd_pkg::FIN_BAND: begin
          m_tvalid         <= 1'b1;
          integral_acc     <= '0;
          previous_error   <= err;
          last_update_time <= now;
        end
        phd_pkg::FIN_ZERO: begin
          m_tvalid <= 1'b1;
        end
        phd_pkg::FIN_PID: begin
          m_tvalid         <= 1'b1;
          previous_error   <= err;
          last_update_time <= now;
          if (wrap) begin
            window_start_time <= now;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err       <= err_in;
      now       <= now_in;
      dt        <= now_in - last_update_time;
      acid_busy <= s_tdata[phd_pkg::PH_W + phd_pkg::TIME_W];
      base_busy <= s_tdata[phd_pkg::PH_W + phd_pkg::TIME_W + 1];
    end
    if (cmd.ld_prod) begin
      prod <= mul_y;
    end
    dnum <= (prod_s <<< 10) - (prod_s <<< 4) - (prod_s <<< 3);
    if (cmd.ld_sum_p) begin
      sum <= prod_s;
    end
    if (cmd.div_start) begin
      q_neg <= div_src[phd_pkg::SUM_W-1];
    end
    if (cmd.add_q) begin
      sum <= sum + quot_s;
    end
    case (cmd.fin)
      phd_pkg::FIN_BAND: begin
        acid_action <= acid_busy ? phd_pkg::ACT_KEEP : phd_pkg::ACT_LOW;
        base_action <= base_busy ? phd_pkg::ACT_KEEP : phd_pkg::ACT_LOW;
        pulse_ms    <= '0;
        in_deadband <= 1'b1;
      end
      phd_pkg::FIN_ZERO: begin
        acid_action <= phd_pkg::ACT_KEEP;
        base_action <= phd_pkg::ACT_KEEP;
        pulse_ms    <= '0;
        in_deadband <= 1'b0;
      end
      phd_pkg::FIN_PID: begin
        if (!err[phd_pkg::ERR_W-1] && (err != '0)) begin
          acid_action <= acid_busy ? phd_pkg::ACT_KEEP : drive;
          base_action <= base_busy ? phd_pkg::ACT_KEEP : phd_pkg::ACT_LOW;
        end else begin
          acid_action <= acid_busy ? phd_pkg::ACT_KEEP : phd_pkg::ACT_LOW;
          base_action <= base_busy ? phd_pkg::ACT_KEEP : drive;
        end
        pulse_ms    <= pulse;
        in_deadband <= 1'b0;
      end
      default: ;
    endcase
  end

  assign m_tdata = {6'd0, in_deadband, pulse_ms, base_action, acid_action};

endmodule

[design/phd_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phd_controller
// Sequencer for one update: capture, classify, integral, P, I and D terms,
// then result hand-off.
// ----------------------------------------------------------------------------
module phd_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  phd_pkg::status_t status,
  output phd_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EVAL   = 4'd1;
  localparam logic [3:0] ST_CLAMP  = 4'd2;
  localparam logic [3:0] ST_PSUM   = 4'd3;
  localparam logic [3:0] ST_ISTART = 4'd4;
  localparam logic [3:0] ST_IWAIT  = 4'd5;
  localparam logic [3:0] ST_DWAIT  = 4'd6;
  localparam logic [3:0] ST_FBAND  = 4'd7;
  localparam logic [3:0] ST_FZERO  = 4'd8;
  localparam logic [3:0] ST_FPID   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.fin    = phd_pkg::FIN_NONE;
    cmd.mul_op = phd_pkg::MUL_EDT;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.band) begin
          state_next = ST_FBAND;
        end else if (status.dt_zero) begin
          state_next = ST_FZERO;
        end else begin
          cmd.ld_prod = 1'b1;
          cmd.mul_op  = phd_pkg::MUL_EDT;
          state_next  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.ld_integ = 1'b1;
        cmd.ld_prod  = 1'b1;
        cmd.mul_op   = phd_pkg::MUL_P;
        state_next   = ST_PSUM;
      end
      ST_PSUM: begin
        cmd.ld_sum_p = 1'b1;
        cmd.ld_prod  = 1'b1;
        cmd.mul_op   = phd_pkg::MUL_I;
        state_next   = ST_ISTART;
      end
      ST_ISTART: begin
        cmd.div_start = 1'b1;
        cmd.ld_prod   = 1'b1;
        cmd.mul_op    = phd_pkg::MUL_D;
        state_next    = ST_IWAIT;
      end
      ST_IWAIT: begin
        if (!status.div_busy) begin
          cmd.add_q     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_d = 1'b1;
          state_next    = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (!status.div_busy) begin
          cmd.add_q  = 1'b1;
          state_next = ST_FPID;
        end
      end
      ST_FBAND: begin
        if (status.out_free) begin
          cmd.fin    = phd_pkg::FIN_BAND;
          state_next = ST_IDLE;
        end
      end
      ST_FZERO: begin
        if (status.out_free) begin
          cmd.fin    = phd_pkg::FIN_ZERO;
          state_next = ST_IDLE;
        end
      end
      ST_FPID: begin
        if (status.out_free) begin
          cmd.fin    = phd_pkg::FIN_PID;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/ph_dosing_pid_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_dosing_pid_controller_unit
// pH dosing PID controller with time-proportioned acid/base pump drive.
// ----------------------------------------------------------------------------
// One update word in, one result word out. An update inside the deadband,
// or one with no time elapsed, skips the arithmetic. A full PID update
// runs capture and classify, the shared multiplier for the integral, P, I
// and D products, then two runs of the two-bit-per-cycle divider for the
// integral scaling and the derivative over dt, and then hands the result
// to the output register. A new word is taken once the previous update has
// been handed off, while its result may still wait at the output.
module ph_dosing_pid_controller_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [phd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // ph_measured[13:0], now_ms[45:14], acid_manual_busy[46], base_manual_busy[47]
  input  logic [phd_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // acid_action[1:0], base_action[3:2], pulse_ms[16:4], in_deadband[17], zero
  output logic [phd_pkg::OUT_DATA_W-1:0]  m_tdata
);

  phd_pkg::cmd_t    cmd;
  phd_pkg::status_t status;

  assign cfg_ready = 1'b1;

  phd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  phd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[tb/sv/tb_ph_dosing_pid_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ph_dosing_pid_controller_unit
// Self-checking bench for the pH dosing PID controller. A queue-fed driver
// streams update words and mirrors every accepted word through its own
// fixed-point model of the controller. The monitor compares each result
// word field by field with the oldest predicted dose. Directed updates
// cover the deadband, zero elapsed time, window rollover, timestamp wrap,
// busy pumps and zero error. Random phases follow, each with its own
// register settings and one of four idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_ph_dosing_pid_controller_unit;
  import phd_pkg::*;

  typedef struct packed {
    logic            base_busy;
    logic            acid_busy;
    logic [TIME_W-1:0] now_ms;
    logic [PH_W-1:0]   ph;
  } upd_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic               in_band;
    logic [PULSE_W-1:0] pulse;
    logic [ACT_W-1:0]   base_act;
    logic [ACT_W-1:0]   acid_act;
  } dose_t;

  localparam longint ACC_CLAMP = longint'(INTEG_LIM);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  upd_t  pending_updates[$];
  dose_t expected_doses[$];
  dose_t dose_got, dose_want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_errors = 0;
  int n_updates = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_high = 0;
  int n_band = 0;
  logic [TIME_W-1:0] t_cursor = '0;

  logic [PH_W-1:0]   pv_target;
  logic [DB_W-1:0]   pv_band;
  logic [GAIN_W-1:0] pv_kp, pv_ki, pv_kd;
  longint            pv_integ, pv_prev;
  logic [TIME_W-1:0] pv_last, pv_win;

  ph_dosing_pid_controller_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb_ph_dosing_pid_controller_unit NOT OK");
    $finish;
  end

  function automatic dose_t predict_dose(upd_t u);
    dose_t             r;
    longint            e, mag, acc, de, sum, smag, pulse;
    logic [TIME_W-1:0] dt, wt;
    logic [ACT_W-1:0]  drive;
    r = '0;
    e = longint'(u.ph) - longint'(pv_target);
    mag = (e < 0) ? -e : e;
    dt = u.now_ms - pv_last;
    if (mag < longint'(pv_band)) begin
      r.acid_act = u.acid_busy ? ACT_KEEP : ACT_LOW;
      r.base_act = u.base_busy ? ACT_KEEP : ACT_LOW;
      r.in_band = 1'b1;
      pv_integ = 0;
      pv_prev = e;
      pv_last = u.now_ms;
    end else if (dt != '0) begin
      acc = pv_integ + e * longint'(dt);
      if (acc > ACC_CLAMP) acc = ACC_CLAMP;
      if (acc < -ACC_CLAMP) acc = -ACC_CLAMP;
      pv_integ = acc;
      de = e - pv_prev;
      sum = longint'(pv_kp) * e;
      sum += (longint'(pv_ki) * acc) / 1000;
      sum += (longint'(pv_kd) * de * 1000) / longint'(dt);
      smag = (sum < 0) ? -sum : sum;
      pulse = smag >> 18;
      if (pulse > longint'(MAX_PULSE_MS)) pulse = longint'(MAX_PULSE_MS);
      wt = u.now_ms - pv_win;
      if (wt >= WINDOW_MS) begin
        pv_win = u.now_ms;
        wt = '0;
      end
      drive = (longint'(wt) < pulse) ? ACT_HIGH : ACT_LOW;
      if (e > 0) begin
        r.acid_act = u.acid_busy ? ACT_KEEP : drive;
        r.base_act = u.base_busy ? ACT_KEEP : ACT_LOW;
      end else begin
        r.base_act = u.base_busy ? ACT_KEEP : drive;
        r.acid_act = u.acid_busy ? ACT_KEEP : ACT_LOW;
      end
      r.pulse = pulse[PULSE_W-1:0];
      pv_prev = e;
      pv_last = u.now_ms;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < 20)
      $display("mismatch at result %0d: %s got %0h expected %0h", n_checked, what, got, want);
    n_errors++;
  endtask

  // driver: register and update predictor, stream feed
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      pv_target = TARGET_RESET;
      pv_band = DEADBAND_RESET;
      pv_kp = GAIN_P_RESET;
      pv_ki = GAIN_I_RESET;
      pv_kd = GAIN_D_RESET;
      pv_integ = 0;
      pv_prev = 0;
      pv_last = '0;
      pv_win = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET:   pv_target = cfg_data[PH_W-1:0];
          CFG_DEADBAND: pv_band = cfg_data[DB_W-1:0];
          CFG_GAIN_P:   pv_kp = cfg_data;
          CFG_GAIN_I:   pv_ki = cfg_data;
          CFG_GAIN_D:   pv_kd = cfg_data;
          default: ;
        endcase
        n_writes++;
      end
      if (s_tvalid && s_tready) begin
        expected_doses.push_back(predict_dose(upd_t'(s_tdata)));
        n_updates++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_updates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= pending_updates.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        dose_got = dose_t'(m_tdata);
        if (expected_doses.size() == 0) begin
          flag_mismatch("result word with nothing expected", m_tdata, '0);
        end else begin
          dose_want = expected_doses.pop_front();
          if (dose_got.acid_act !== dose_want.acid_act)
            flag_mismatch("acid_action", dose_got.acid_act, dose_want.acid_act);
          if (dose_got.base_act !== dose_want.base_act)
            flag_mismatch("base_action", dose_got.base_act, dose_want.base_act);
          if (dose_got.pulse !== dose_want.pulse)
            flag_mismatch("pulse_ms", dose_got.pulse, dose_want.pulse);
          if (dose_got.in_band !== dose_want.in_band)
            flag_mismatch("in_deadband", dose_got.in_band, dose_want.in_band);
          if (dose_got.pad !== dose_want.pad)
            flag_mismatch("padding", dose_got.pad, dose_want.pad);
          if (dose_want.acid_act == ACT_HIGH || dose_want.base_act == ACT_HIGH) n_high++;
          if (dose_want.in_band) n_band++;
          n_checked++;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_updates.size() != 0 || s_tvalid || expected_doses.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_update(int ph, logic [TIME_W-1:0] now, bit acid_busy, bit base_busy);
    upd_t u;
    u.ph = PH_W'(ph);
    u.now_ms = now;
    u.acid_busy = acid_busy;
    u.base_busy = base_busy;
    pending_updates.push_back(u);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(9))
      0: pick_gain = '0;
      1: pick_gain = '1;
      2, 3: pick_gain = GAIN_W'($urandom());
      default: pick_gain = GAIN_W'($urandom_range(51200));
    endcase
  endfunction

  task automatic configure_random();
    case ($urandom_range(9))
      0: write_reg(CFG_TARGET, '0);
      1: write_reg(CFG_TARGET, CFG_DATA_W'(14'h3FFF));
      2: write_reg(CFG_TARGET, CFG_DATA_W'($urandom_range(16383)));
      default: write_reg(CFG_TARGET, CFG_DATA_W'($urandom_range(9216, 5120)));
    endcase
    case ($urandom_range(9))
      0: write_reg(CFG_DEADBAND, '0);
      1: write_reg(CFG_DEADBAND, CFG_DATA_W'(12'hFFF));
      2: write_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(4095)));
      default: write_reg(CFG_DEADBAND, CFG_DATA_W'($urandom_range(300)));
    endcase
    write_reg(CFG_GAIN_P, pick_gain());
    write_reg(CFG_GAIN_I, pick_gain());
    write_reg(CFG_GAIN_D, pick_gain());
    if ($urandom_range(1) == 0)
      write_reg(CFG_GAIN_D + CFG_IDX_W'($urandom_range(3, 1)), CFG_DATA_W'($urandom()));
  endtask

  task automatic queue_random_updates(int count);
    int span, ph;
    for (int k = 0; k < count; k++) begin
      span = int'(pv_band) + 512;
      ph = int'(pv_target) - span + int'($urandom_range(2 * span));
      case ($urandom_range(9))
        0: ;
        1: begin
          ph = $urandom_range(16383);
          t_cursor += $urandom_range(500, 1);
        end
        2: t_cursor = $urandom();
        default: t_cursor += $urandom_range(3000, 1);
      endcase
      if (ph < 0) ph = 0;
      if (ph > 16383) ph = 16383;
      queue_update(ph, t_cursor, $urandom_range(99) < 15, $urandom_range(99) < 15);
    end
  endtask

  initial begin
    wait (rst == 1'b0);
    @(negedge clk);

    // reset settings: deadband edge, no elapsed time, window edges, wrap
    queue_update(7168, 32'd0, 0, 0);
    queue_update(7269, 32'd3, 1, 0);
    queue_update(7066, 32'd3, 0, 1);
    queue_update(7066, 32'd50, 0, 1);
    queue_update(16383, 32'd150, 0, 0);
    queue_update(16383, 32'd9999, 0, 0);
    queue_update(16383, 32'd10000, 0, 0);
    queue_update(0, 32'd10500, 1, 1);
    queue_update(0, 32'hFFFF_FFFF, 0, 0);
    queue_update(0, 32'h0000_0010, 0, 0);
    queue_update(7168, 32'h0000_0010, 1, 1);
    wait_idle();

    // top gains, no deadband, top setpoint: zero error, integral clamp
    write_reg(CFG_GAIN_P, '1);
    write_reg(CFG_GAIN_I, '1);
    write_reg(CFG_GAIN_D, '1);
    write_reg(CFG_DEADBAND, '0);
    write_reg(CFG_TARGET, CFG_DATA_W'(14'h3FFF));
    for (int k = 1; k <= 3; k++)
      write_reg(CFG_GAIN_D + CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
    wait_idle();
    send_idle_pct = 84;
    queue_update(16383, 32'h0000_0020, 0, 0);
    queue_update(0, 32'h0000_1020, 0, 0);
    queue_update(16383, 32'h0000_1021, 0, 0);
    queue_update(16383, 32'h0000_1021, 0, 0);
    queue_update(16382, 32'h0000_1100, 0, 1);
    wait_idle();

    // zero setpoint, widest deadband, zero gains
    write_reg(CFG_TARGET, '0);
    write_reg(CFG_DEADBAND, CFG_DATA_W'(12'hFFF));
    write_reg(CFG_GAIN_P, '0);
    write_reg(CFG_GAIN_I, '0);
    write_reg(CFG_GAIN_D, '0);
    wait_idle();
    recv_stall_pct = 84;
    queue_update(0, 32'h0000_2000, 0, 0);
    queue_update(16383, 32'h0000_2001, 0, 0);
    wait_idle();

    t_cursor = $urandom();
    for (int pass_no = 0; pass_no < 8; pass_no++) begin
      configure_random();
      @(negedge clk);
      case (pass_no % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      queue_random_updates(250);
      wait_idle();
    end

    repeat (60) @(negedge clk);
    if (expected_doses.size() != 0)
      flag_mismatch("results never delivered", expected_doses.size(), 0);
    $display("covered %0d updates and %0d register writes over 11 phases", n_updates, n_writes);
    $display("checked %0d results: %0d in deadband, %0d with a pump driven high",
             n_checked, n_band, n_high);
    if (n_errors == 0) begin
      $display("tb_ph_dosing_pid_controller_unit OK");
    end else begin
      $display("tb_ph_dosing_pid_controller_unit NOT OK");
    end
    $finish;
  end

endmodule

[ph_dosing_pid_controller_unit.f]
design/phd_pkg.sv
design/phd_divider.sv
design/phd_datapath.sv
design/phd_controller.sv
design/ph_dosing_pid_controller_unit.sv
tb/sv/tb_ph_dosing_pid_controller_unit.sv
